/* rtl/dmc_pkg.sv */
// Shared constants, codes and control types for the direct-mapped write-through cache.
`default_nettype none
package dmc_pkg;

    localparam int CACHE_LINES = 16;
    localparam int LINE_BITS   = $clog2(CACHE_LINES);
    localparam int TAG_BITS    = 8;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = TAG_BITS + LINE_BITS;
    localparam int MEM_DEPTH   = 2 ** ADDR_BITS;
    localparam int LAT_BITS    = 16;
    localparam int COST_BITS   = LAT_BITS + 1;
    localparam int CFG_IDX_BITS = 1;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CACHE_LATENCY  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEMORY_LATENCY = 1'b1;

    localparam logic [LAT_BITS-1:0] CACHE_LATENCY_RESET  = 16'd1;
    localparam logic [LAT_BITS-1:0] MEMORY_LATENCY_RESET = 16'd100;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic finish;
        logic clear_step;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic slot_free;
    } status_t;

endpackage
`default_nettype wire

/* rtl/dmc_ctrl.sv */
// Controller state machine: backing store clear, item accept and result hand-off.
`default_nettype none
module dmc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dmc_pkg::status_t status,
    output dmc_pkg::cmd_t    cmd
);
    import dmc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.finish     = 1'b0;
        cmd.clear_step = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = status.slot_free;
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/dmc_datapath.sv */
// Datapath: line arrays, backing store memory, latency registers and result register.
`default_nettype none
module dmc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dmc_pkg::cmd_t                       cmd,
    output dmc_pkg::status_t                    status,
    input  logic                                cfg_we,
    input  logic [dmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [dmc_pkg::LAT_BITS-1:0]        cfg_data,
    input  logic                                func,
    input  logic [dmc_pkg::TAG_BITS-1:0]        tag,
    input  logic [dmc_pkg::LINE_BITS-1:0]       line_index,
    input  logic [dmc_pkg::DATA_BITS-1:0]       write_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dmc_pkg::DATA_BITS-1:0]       read_value,
    output logic                                hit,
    output logic [dmc_pkg::COST_BITS-1:0]       cost_cycles
);
    import dmc_pkg::*;

    logic [LAT_BITS-1:0]  cache_lat_reg;
    logic [LAT_BITS-1:0]  mem_lat_reg;
    logic [ADDR_BITS-1:0] clear_cnt_reg;

    logic                 func_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [LINE_BITS-1:0] line_reg;
    logic [DATA_BITS-1:0] data_reg;

    logic [CACHE_LINES-1:0] line_valid_reg;
    logic [TAG_BITS-1:0]    line_tag_reg  [CACHE_LINES];
    logic [DATA_BITS-1:0]   line_word_reg [CACHE_LINES];

    logic [DATA_BITS-1:0] mem [MEM_DEPTH];
    logic [DATA_BITS-1:0] mem_rdata_reg;

    logic                 out_valid_reg;
    logic [DATA_BITS-1:0] read_value_reg;
    logic                 hit_reg;
    logic [COST_BITS-1:0] cost_reg;

    logic                 lookup_hit;
    logic                 use_memory;
    logic [DATA_BITS-1:0] result_value;
    logic [COST_BITS-1:0] result_cost;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [DATA_BITS-1:0] mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_lat_reg <= CACHE_LATENCY_RESET;
            mem_lat_reg   <= MEMORY_LATENCY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CACHE_LATENCY:  cache_lat_reg <= cfg_data;
                CFG_MEMORY_LATENCY: mem_lat_reg   <= cfg_data;
                default:            cache_lat_reg <= cache_lat_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_cnt_reg <= clear_cnt_reg + ADDR_BITS'(1);
        end
    end

    assign status.clear_last = (clear_cnt_reg == ADDR_BITS'(MEM_DEPTH - 1));
    assign status.slot_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            tag_reg  <= tag;
            line_reg <= line_index;
            data_reg <= write_data;
        end
    end

    assign lookup_hit   = line_valid_reg[line_reg] && (line_tag_reg[line_reg] == tag_reg);
    assign use_memory   = (func_reg == FUNC_WRITE) || !lookup_hit;
    assign result_value = (func_reg == FUNC_WRITE) ? data_reg :
                          (lookup_hit ? line_word_reg[line_reg] : mem_rdata_reg);
    assign result_cost  = {1'b0, cache_lat_reg} +
                          (use_memory ? {1'b0, mem_lat_reg} : '0);

    assign mem_we    = cmd.clear_step || (cmd.finish && func_reg == FUNC_WRITE);
    assign mem_waddr = cmd.clear_step ? clear_cnt_reg : {tag_reg, line_reg};
    assign mem_wdata = cmd.clear_step ? '0 : data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            mem_rdata_reg <= mem[{tag, line_index}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
        end
        else if (cmd.finish && use_memory)
        begin
            line_valid_reg[line_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && use_memory)
        begin
            line_tag_reg[line_reg]  <= tag_reg;
            line_word_reg[line_reg] <= result_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_value_reg <= result_value;
            hit_reg        <= lookup_hit;
            cost_reg       <= result_cost;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign hit         = hit_reg;
    assign cost_cycles = cost_reg;

`ifndef SYNTHESIS
    // The clearing pass and item completion never share the memory write port.
    a_no_clear_with_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_step && (cmd.finish || cmd.accept)))
        else $error("clear step overlaps item traffic");

    // A completed item always leaves a result waiting.
    a_finish_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result register not loaded on finish");

    // After any completed item its line holds the item's tag.
    a_line_filled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (line_valid_reg[line_reg] && line_tag_reg[line_reg] == tag_reg))
        else $error("line not filled after item");
`endif

endmodule
`default_nettype wire

/* rtl/direct_mapped_cache_write_through.sv */
// Top level of the direct-mapped write-through cache with its backing store.
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, func, tag,            | input item
//          | line_index, write_data                    |
//  out     | out_valid, out_ready, read_value, hit,    | result item
//          | cost_cycles                               |
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// Each item has two steps: the accept cycle issues the backing store read,
// and the finish state, once the output slot is free, forms the result
// and does the line fill or write-through. The store read is registered.
// After reset a clearing pass zeroes the 4096-word backing store with
// in_ready low; register writes are taken during it.
// A result waiting in the output register and not taken holds the finish step of the next item.
`default_nettype none
module direct_mapped_cache_write_through (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [dmc_pkg::LAT_BITS-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [dmc_pkg::TAG_BITS-1:0]        tag,
    input  logic [dmc_pkg::LINE_BITS-1:0]       line_index,
    input  logic signed [dmc_pkg::DATA_BITS-1:0] write_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dmc_pkg::DATA_BITS-1:0] read_value,
    output logic                                hit,
    output logic [dmc_pkg::COST_BITS-1:0]       cost_cycles
);
    import dmc_pkg::*;

    cmd_t    cmd;
    status_t status;

    dmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dmc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .tag         (tag),
        .line_index  (line_index),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .hit         (hit),
        .cost_cycles (cost_cycles)
    );

endmodule
`default_nettype wire
